FILE: hw/rtl/tefs_pkg.sv
// ============================================================================
// tefs_pkg
// Shared types, widths and helpers for the truss element force and stiffness
// pipeline.
// ============================================================================
`default_nettype none

package tefs_pkg;

    // Field width of every Q16.16 value on the ports.
    localparam int IN_W        = 32;
    // Widths of the bar vector and of its magnitude.
    localparam int RX_W        = 35;
    localparam int MAG_W       = 34;
    localparam int SQ_P_W      = 2 * MAG_W;
    // Square root: one result bit per stage.
    localparam int SQ_STAGES   = 35;
    localparam int SQ_RAD_W    = 2 * SQ_STAGES;
    localparam int SQ_ROOT_W   = SQ_STAGES;
    localparam int SQ_REM_W    = SQ_ROOT_W + 2;
    // Divider: one quotient bit per stage.
    localparam int DIV_W       = 64;
    localparam int DIV_STAGES  = DIV_W;
    // Fixed point scalings.
    localparam int FRAC_W      = 16;
    localparam int UNIT_W      = 30;
    localparam int CROSS_W     = 28;
    localparam int U_W         = UNIT_W + 1;
    localparam int PROD_W      = 2 * U_W;
    // Signed accumulator wide enough for every difference before clamping.
    localparam int ACC_W       = 66;
    // Register stages from the input register to the result register.
    localparam int PIPE_STAGES = 4 + SQ_STAGES + 1 + DIV_STAGES + 2 + DIV_STAGES + 1;
    // Numerator of the reciprocal 1.0 / L in Q16.16.
    localparam logic [DIV_W-1:0] RECIP_NUM = DIV_W'(1) << (2 * FRAC_W);

    // One element request.
    typedef struct packed {
        logic signed [IN_W-1:0] ref_ax;
        logic signed [IN_W-1:0] ref_ay;
        logic signed [IN_W-1:0] ref_bx;
        logic signed [IN_W-1:0] ref_by;
        logic signed [IN_W-1:0] disp_ax;
        logic signed [IN_W-1:0] disp_ay;
        logic signed [IN_W-1:0] disp_bx;
        logic signed [IN_W-1:0] disp_by;
    } t_req;

    // One element result.
    typedef struct packed {
        logic signed [IN_W-1:0] force_bx;
        logic signed [IN_W-1:0] force_by;
        logic signed [IN_W-1:0] stiff_xx;
        logic signed [IN_W-1:0] stiff_xy;
        logic signed [IN_W-1:0] stiff_yy;
        logic                   degenerate;
    } t_rsp;

    // Clamp a wide signed value to the Q16.16 range.
    function automatic logic signed [IN_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-IN_W:0] top;
        logic signed [IN_W-1:0] res;
        top = v[ACC_W-1:IN_W-1];
        if (top == '0 || top == '1) begin
            res = v[IN_W-1:0];
        end else if (v[ACC_W-1]) begin
            res = {1'b1, {(IN_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(IN_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tefs_div.sv
// ============================================================================
// tefs_div
// Pipelined restoring divider, one quotient bit per register stage.
// ============================================================================
`default_nettype none

module tefs_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [tefs_pkg::DIV_W-1:0] i_num,
    input  wire logic [tefs_pkg::DIV_W-1:0] i_den,
    output logic      [tefs_pkg::DIV_W-1:0] o_quo
);

    localparam int W = tefs_pkg::DIV_W;
    localparam int N = tefs_pkg::DIV_STAGES;

    // Partial remainder, numerator/quotient shift word and divisor per stage.
    logic [W-1:0] r_rem [0:N-2];
    logic [W-1:0] r_den [0:N-2];
    logic [W-1:0] r_acc [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [W-1:0] s_rem;
        logic [W-1:0] s_acc;
        logic [W-1:0] s_den;
        logic [W:0]   shl;
        logic         ge;
        logic [W-1:0] n_rem;

        if (k == 0) begin : g_first
            assign s_rem = '0;
            assign s_acc = i_num;
            assign s_den = i_den;
        end else begin : g_next
            assign s_rem = r_rem[k-1];
            assign s_acc = r_acc[k-1];
            assign s_den = r_den[k-1];
        end

        // Bring down the next numerator bit and try the subtraction.
        assign shl   = {s_rem, s_acc[W-1]};
        assign ge    = shl >= {1'b0, s_den};
        assign n_rem = ge ? W'(shl - {1'b0, s_den}) : shl[W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k] <= {s_acc[W-2:0], ge};
            end
        end

        if (k < N - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= s_den;
                end
            end
        end
    end

    assign o_quo = r_acc[N-1];

endmodule

`default_nettype wire

FILE: hw/rtl/truss_element_force_stiffness.sv
// ============================================================================
// truss_element_force_stiffness
// Force on node B and 2x2 tangent stiffness block of a two-node plane bar,
// signed Q16.16, fully pipelined.
// ============================================================================
//
//  Channel   Direction  Signals                            Payload
//  --------  ---------  ---------------------------------  ---------------
//  request   in         i_req_valid, o_req_ready, i_req    tefs_pkg::t_req
//  response  out        o_rsp_valid, i_rsp_ready, o_rsp    tefs_pkg::t_rsp
//
//  One request enters per cycle while the skid slot is empty (o_req_ready high); a
//  result passes through 171 pipeline stages plus the output register. The depth
//  is set by two digit-by-digit square roots (35 stages) and two chained rows of
//  64-stage dividers.
//  Reset (synchronous, active low) clears all valid bits, including those of both output slots.
//  When the response side stalls, one more result is parked in a skid slot and
//  then the whole pipeline freezes until the output drains; nothing is lost.
//
`default_nettype none

module truss_element_force_stiffness (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    input  wire tefs_pkg::t_req  i_req,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_ready,
    output tefs_pkg::t_rsp       o_rsp
);

    localparam int MAG_W     = tefs_pkg::MAG_W;
    localparam int RX_W      = tefs_pkg::RX_W;
    localparam int SQ_STAGES = tefs_pkg::SQ_STAGES;
    localparam int ROOT_W    = tefs_pkg::SQ_ROOT_W;
    localparam int REM_W     = tefs_pkg::SQ_REM_W;
    localparam int RAD_W     = tefs_pkg::SQ_RAD_W;
    localparam int DIV_W     = tefs_pkg::DIV_W;
    localparam int DSTG      = tefs_pkg::DIV_STAGES;
    localparam int ACC_W     = tefs_pkg::ACC_W;
    localparam int IN_W      = tefs_pkg::IN_W;
    localparam int NSTG      = tefs_pkg::PIPE_STAGES;

    // Slots of the first divider row.
    localparam int DA_Q1X = 0;
    localparam int DA_Q1Y = 1;
    localparam int DA_Q2X = 2;
    localparam int DA_Q2Y = 3;
    localparam int DA_A1  = 4;
    localparam int DA_A2  = 5;
    localparam int DA_UX  = 6;
    localparam int DA_UY  = 7;
    localparam int DA_N   = 8;
    // Slots of the second divider row.
    localparam int DB_XX  = 0;
    localparam int DB_XY  = 1;
    localparam int DB_YY  = 2;
    localparam int DB_N   = 3;
    // Slots of the difference vectors.
    localparam int V_0X = 0;
    localparam int V_0Y = 1;
    localparam int V_RX = 2;
    localparam int V_RY = 3;

    typedef struct packed {
        logic [MAG_W-1:0] mrx;
        logic [MAG_W-1:0] mry;
        logic             sx;
        logic             sy;
    } t_side1;

    typedef struct packed {
        logic [ROOT_W-1:0] len;
        logic              sx;
        logic              sy;
        logic              deg;
    } t_side2;

    typedef struct packed {
        logic [ROOT_W-1:0]       len;
        logic                    sxy;
        logic                    deg;
        logic signed [IN_W-1:0]  fx;
        logic signed [IN_W-1:0]  fy;
        logic signed [ACC_W-1:0] a;
    } t_side3;

    // Pipeline enable: everything advances unless the skid slot is occupied.
    logic en;
    logic r_skid_v;
    logic r_out_v;
    logic push;
    logic r_vld [0:NSTG-1];

    assign en          = !r_skid_v;
    assign o_req_ready = en;

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_req_valid;
            for (int k = 1; k < NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 1: input register.
    tefs_pkg::t_req r_req;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_req <= i_req;
        end
    end

    // Stage 2: reference and current bar vectors, magnitudes and signs.
    logic signed [RX_W-1:0] dv [0:3];
    logic [MAG_W-1:0]       n_m [0:3];
    logic [MAG_W-1:0]       r_m [0:3];
    t_side1                 n_sd1;

    always_comb begin
        dv[V_0X] = RX_W'(r_req.ref_bx) - RX_W'(r_req.ref_ax);
        dv[V_0Y] = RX_W'(r_req.ref_by) - RX_W'(r_req.ref_ay);
        dv[V_RX] = (RX_W'(r_req.ref_bx) + RX_W'(r_req.disp_bx))
                 - (RX_W'(r_req.ref_ax) + RX_W'(r_req.disp_ax));
        dv[V_RY] = (RX_W'(r_req.ref_by) + RX_W'(r_req.disp_by))
                 - (RX_W'(r_req.ref_ay) + RX_W'(r_req.disp_ay));
        for (int j = 0; j < 4; j++) begin
            n_m[j] = dv[j][RX_W-1] ? MAG_W'(-dv[j]) : MAG_W'(dv[j]);
        end
        n_sd1.mrx = n_m[V_RX];
        n_sd1.mry = n_m[V_RY];
        n_sd1.sx  = dv[V_RX][RX_W-1];
        n_sd1.sy  = dv[V_RY][RX_W-1];
    end

    // Side data waits through stages 2 to 4 and the square roots.
    localparam int SD1_N = SQ_STAGES + 3;
    t_side1 r_sd1 [0:SD1_N-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                r_m[j] <= n_m[j];
            end
            r_sd1[0] <= n_sd1;
            for (int k = 1; k < SD1_N; k++) begin
                r_sd1[k] <= r_sd1[k-1];
            end
        end
    end

    // Stage 3: squares. Stage 4: sums of squares.
    logic [tefs_pkg::SQ_P_W-1:0] r_p [0:3];
    logic [RAD_W-1:0]            r_rad_in [0:1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                r_p[j] <= tefs_pkg::SQ_P_W'(r_m[j]) * tefs_pkg::SQ_P_W'(r_m[j]);
            end
            r_rad_in[0] <= RAD_W'(r_p[V_0X]) + RAD_W'(r_p[V_0Y]);
            r_rad_in[1] <= RAD_W'(r_p[V_RX]) + RAD_W'(r_p[V_RY]);
        end
    end

    // Two digit-by-digit square roots: unit 0 gives L0, unit 1 gives len.
    logic [RAD_W-1:0]  r_sq_rad  [0:1][0:SQ_STAGES-2];
    logic [REM_W-1:0]  r_sq_rem  [0:1][0:SQ_STAGES-2];
    logic [ROOT_W-1:0] r_sq_root [0:1][0:SQ_STAGES-1];

    for (genvar u = 0; u < 2; u++) begin : g_sqrt
        for (genvar k = 0; k < SQ_STAGES; k++) begin : g_step
            logic [RAD_W-1:0]  rad;
            logic [ROOT_W-1:0] root;
            logic [REM_W-1:0]  rem;
            logic [REM_W+1:0]  rem2;
            logic [REM_W+1:0]  trial;
            logic              ge;

            if (k == 0) begin : g_first
                assign rad  = r_rad_in[u];
                assign root = '0;
                assign rem  = '0;
            end else begin : g_next
                assign rad  = r_sq_rad[u][k-1];
                assign root = r_sq_root[u][k-1];
                assign rem  = r_sq_rem[u][k-1];
            end

            // Append the next bit pair and test root*4+1 against it.
            assign rem2  = {rem, rad[RAD_W-1 -: 2]};
            assign trial = (REM_W + 2)'({root, 2'b01});
            assign ge    = rem2 >= trial;

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq_root[u][k] <= {root[ROOT_W-2:0], ge};
                end
            end

            if (k < SQ_STAGES - 1) begin : g_keep
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_sq_rad[u][k] <= rad << 2;
                        r_sq_rem[u][k] <= ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
                    end
                end
            end
        end
    end

    // Stage 5: operands of the first divider row, rounding half added up front.
    logic [ROOT_W-1:0] l0;
    logic [ROOT_W-1:0] len5;
    t_side1            sd1_q;
    t_side2            n_sd2;
    logic [DIV_W-1:0]  n_anum [0:DA_N-1];
    logic [DIV_W-1:0]  n_aden [0:DA_N-1];
    logic [DIV_W-1:0]  r_anum [0:DA_N-1];
    logic [DIV_W-1:0]  r_aden [0:DA_N-1];

    assign l0    = r_sq_root[0][SQ_STAGES-1];
    assign len5  = r_sq_root[1][SQ_STAGES-1];
    assign sd1_q = r_sd1[SD1_N-1];

    always_comb begin
        n_anum[DA_Q1X] = DIV_W'({sd1_q.mrx, {tefs_pkg::FRAC_W{1'b0}}}) + DIV_W'(l0 >> 1);
        n_anum[DA_Q1Y] = DIV_W'({sd1_q.mry, {tefs_pkg::FRAC_W{1'b0}}}) + DIV_W'(l0 >> 1);
        n_anum[DA_Q2X] = DIV_W'({sd1_q.mrx, {tefs_pkg::FRAC_W{1'b0}}}) + DIV_W'(len5 >> 1);
        n_anum[DA_Q2Y] = DIV_W'({sd1_q.mry, {tefs_pkg::FRAC_W{1'b0}}}) + DIV_W'(len5 >> 1);
        n_anum[DA_A1]  = tefs_pkg::RECIP_NUM + DIV_W'(l0 >> 1);
        n_anum[DA_A2]  = tefs_pkg::RECIP_NUM + DIV_W'(len5 >> 1);
        // The unit vector numerator may wrap at 64 bits.
        n_anum[DA_UX]  = DIV_W'({sd1_q.mrx, {tefs_pkg::UNIT_W{1'b0}}}) + DIV_W'(len5 >> 1);
        n_anum[DA_UY]  = DIV_W'({sd1_q.mry, {tefs_pkg::UNIT_W{1'b0}}}) + DIV_W'(len5 >> 1);
        n_aden[DA_Q1X] = DIV_W'(l0);
        n_aden[DA_Q1Y] = DIV_W'(l0);
        n_aden[DA_Q2X] = DIV_W'(len5);
        n_aden[DA_Q2Y] = DIV_W'(len5);
        n_aden[DA_A1]  = DIV_W'(l0);
        n_aden[DA_A2]  = DIV_W'(len5);
        n_aden[DA_UX]  = DIV_W'(len5);
        n_aden[DA_UY]  = DIV_W'(len5);
        n_sd2.len = len5;
        n_sd2.sx  = sd1_q.sx;
        n_sd2.sy  = sd1_q.sy;
        n_sd2.deg = (l0 == '0) || (len5 == '0);
    end

    localparam int SD2_N = DSTG + 1;
    t_side2 r_sd2 [0:SD2_N-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < DA_N; j++) begin
                r_anum[j] <= n_anum[j];
                r_aden[j] <= n_aden[j];
            end
            r_sd2[0] <= n_sd2;
            for (int k = 1; k < SD2_N; k++) begin
                r_sd2[k] <= r_sd2[k-1];
            end
        end
    end

    // First divider row.
    logic [DIV_W-1:0] quo_a [0:DA_N-1];

    for (genvar j = 0; j < DA_N; j++) begin : g_div_a
        tefs_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_anum[j]),
            .i_den (r_aden[j]),
            .o_quo (quo_a[j])
        );
    end

    // Stage 6: forces and scalar term, products of unit vector components.
    t_side2                    sd2_q;
    t_side3                    n_sd3;
    logic signed [ACC_W-1:0]   qa [0:DA_N-1];
    logic signed [ACC_W-1:0]   fx6;
    logic signed [ACC_W-1:0]   fy6;
    logic [tefs_pkg::U_W-1:0]  ux;
    logic [tefs_pkg::U_W-1:0]  uy;
    logic [tefs_pkg::PROD_W-1:0] r_pxx;
    logic [tefs_pkg::PROD_W-1:0] r_pxy;
    logic [tefs_pkg::PROD_W-1:0] r_pyy;

    assign sd2_q = r_sd2[SD2_N-1];
    assign ux    = quo_a[DA_UX][tefs_pkg::U_W-1:0];
    assign uy    = quo_a[DA_UY][tefs_pkg::U_W-1:0];

    always_comb begin
        for (int j = 0; j < DA_N; j++) begin
            qa[j] = ACC_W'(quo_a[j]);
        end
        fx6 = sd2_q.sx ? (qa[DA_Q2X] - qa[DA_Q1X]) : (qa[DA_Q1X] - qa[DA_Q2X]);
        fy6 = sd2_q.sy ? (qa[DA_Q2Y] - qa[DA_Q1Y]) : (qa[DA_Q1Y] - qa[DA_Q2Y]);
        n_sd3.len = sd2_q.len;
        n_sd3.sxy = sd2_q.sx ^ sd2_q.sy;
        n_sd3.deg = sd2_q.deg;
        n_sd3.fx  = tefs_pkg::sat32(fx6);
        n_sd3.fy  = tefs_pkg::sat32(fy6);
        n_sd3.a   = qa[DA_A1] - qa[DA_A2];
    end

    localparam int SD3_N = DSTG + 2;
    t_side3 r_sd3 [0:SD3_N-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pxx <= tefs_pkg::PROD_W'(ux) * tefs_pkg::PROD_W'(ux);
            r_pxy <= tefs_pkg::PROD_W'(ux) * tefs_pkg::PROD_W'(uy);
            r_pyy <= tefs_pkg::PROD_W'(uy) * tefs_pkg::PROD_W'(uy);
            r_sd3[0] <= n_sd3;
            for (int k = 1; k < SD3_N; k++) begin
                r_sd3[k] <= r_sd3[k-1];
            end
        end
    end

    // Stage 7: operands of the second divider row, divisor len scaled by 2^28.
    logic [ROOT_W-1:0] len7;
    logic [DIV_W-1:0]  half7;
    logic [DIV_W-1:0]  r_bnum [0:DB_N-1];
    logic [DIV_W-1:0]  r_bden;

    assign len7  = r_sd3[0].len;
    assign half7 = DIV_W'({len7, {(tefs_pkg::CROSS_W - 1){1'b0}}});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bnum[DB_XX] <= DIV_W'(r_pxx) + half7;
            r_bnum[DB_XY] <= DIV_W'(r_pxy) + half7;
            r_bnum[DB_YY] <= DIV_W'(r_pyy) + half7;
            r_bden        <= DIV_W'({len7, {tefs_pkg::CROSS_W{1'b0}}});
        end
    end

    // Second divider row.
    logic [DIV_W-1:0] quo_b [0:DB_N-1];

    for (genvar j = 0; j < DB_N; j++) begin : g_div_b
        tefs_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_bnum[j]),
            .i_den (r_bden),
            .o_quo (quo_b[j])
        );
    end

    // Stage 8: assemble the block entries, clamp, zero out degenerate bars.
    t_side3                  sd3_q;
    logic signed [ACC_W-1:0] cxx;
    logic signed [ACC_W-1:0] cxy;
    logic signed [ACC_W-1:0] cyy;
    tefs_pkg::t_rsp          n_res;
    tefs_pkg::t_rsp          r_res;

    assign sd3_q = r_sd3[SD3_N-1];

    always_comb begin
        cxx = ACC_W'(quo_b[DB_XX]);
        cxy = ACC_W'(quo_b[DB_XY]);
        cyy = ACC_W'(quo_b[DB_YY]);
        if (sd3_q.deg) begin
            n_res            = '0;
            n_res.degenerate = 1'b1;
        end else begin
            n_res.force_bx   = sd3_q.fx;
            n_res.force_by   = sd3_q.fy;
            n_res.stiff_xx   = tefs_pkg::sat32(sd3_q.a + cxx);
            n_res.stiff_xy   = tefs_pkg::sat32(sd3_q.sxy ? -cxy : cxy);
            n_res.stiff_yy   = tefs_pkg::sat32(sd3_q.a + cyy);
            n_res.degenerate = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
        end
    end

    // Output register with a skid slot behind it.
    tefs_pkg::t_rsp r_out;
    tefs_pkg::t_rsp r_skid;

    assign push = en && r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_rsp_ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= push;
                r_out    <= r_res;
            end
        end else if (push) begin
            r_skid_v <= 1'b1;
            r_skid   <= r_res;
        end
    end

    assign o_rsp_valid = r_out_v;
    assign o_rsp       = r_out;

    // The skid slot only holds a result while the output register is full.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid slot occupied with empty output register");

    // A result arriving at a stalled output is parked, not dropped.
    a_park_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_rsp_ready && push) |=> r_skid_v)
        else $error("result lost at stalled output");

    // A frozen pipeline keeps its last stage.
    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld[NSTG-1]))
        else $error("pipeline moved while frozen");

    // Degenerate bars report all-zero results.
    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.degenerate) |->
            (r_out.force_bx == '0 && r_out.force_by == '0 && r_out.stiff_xx == '0
             && r_out.stiff_xy == '0 && r_out.stiff_yy == '0))
        else $error("degenerate result with nonzero fields");

endmodule

`default_nettype wire
